>>> hdl/cv3_pkg.sv
// Shared constants, register indexes and types for the 3x3 convolution unit.
`default_nettype none

package cv3_pkg;

    // Field and register widths
    localparam int OUT_BITS    = 28;
    localparam int WEIGHT_BITS = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;
    localparam int DIM_REG_W   = 11;
    localparam int ROW_W       = 11;

    // Input row counter saturates here
    localparam logic [ROW_W-1:0] ROW_MAX = '1;

    // Defaults for the top level parameters
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_PIXEL_BITS = 8;

    // Output queue
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_MIDDLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_BOTTOM = 3'd4;

    // Register reset values (middle row: center weight 1.0)
    localparam logic [DIM_REG_W-1:0]  RST_FRAME_WIDTH    = 11'd3;
    localparam logic [DIM_REG_W-1:0]  RST_FRAME_HEIGHT   = 11'd3;
    localparam logic [CFG_DATA_W-1:0] RST_WEIGHTS_TOP    = 48'h0;
    localparam logic [CFG_DATA_W-1:0] RST_WEIGHTS_MIDDLE = 48'h0000_0100_0000;
    localparam logic [CFG_DATA_W-1:0] RST_WEIGHTS_BOTTOM = 48'h0;

    // Control for one window tap
    typedef struct packed {
        logic en;     // pipeline advances
        logic shift;  // a word enters the window row
        logic keep;   // neighbor lies inside the frame
    } cv3_tap_ctl_t;

    // Border keep flags for one output
    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
    } cv3_keep_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } cv3_div_stat_t;

    // One result word
    typedef struct packed {
        logic signed [OUT_BITS-1:0] filtered;
        logic                       last;
    } cv3_res_t;

endpackage

`default_nettype wire

>>> hdl/cv3_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cv3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/cv3_tap.sv
// One window tap cell: holds a pixel, passes it left, registers its weighted product.
`default_nettype none

module cv3_tap #(
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire cv3_pkg::cv3_tap_ctl_t                       ctl,
    input  wire logic        [PIXEL_BITS-1:0]                pix_in,
    input  wire logic signed [cv3_pkg::WEIGHT_BITS-1:0]      weight,
    output logic             [PIXEL_BITS-1:0]                pix_out,
    output logic signed [cv3_pkg::WEIGHT_BITS+PIXEL_BITS:0]  prod
);

    import cv3_pkg::*;

    localparam int PROD_W = WEIGHT_BITS + PIXEL_BITS + 1;

    logic              [PIXEL_BITS-1:0] pix_reg;
    logic signed       [PROD_W-1:0]     prod_reg;
    logic signed       [PROD_W-1:0]     prod_next;

    // Pixel shift register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg <= '0;
        end
        else if (ctl.en && ctl.shift)
        begin
            pix_reg <= pix_in;
        end
    end

    // Weighted product, zero outside the frame (signed multiply on its own branch)
    always_comb
    begin
        if (ctl.keep)
        begin
            prod_next = weight * $signed({1'b0, pix_reg});
        end
        else
        begin
            prod_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign pix_out = pix_reg;
    assign prod    = prod_reg;

endmodule

`default_nettype wire

>>> hdl/cv3_div.sv
// Restoring divider, one quotient bit a cycle, for output row and column recovery.
`default_nettype none

module cv3_div #(
    parameter int DVD_W = 22,
    parameter int DVS_W = 11
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [DVD_W-1:0]       dividend,
    input  wire logic [DVS_W-1:0]       divisor,
    output cv3_pkg::cv3_div_stat_t      stat,
    output logic      [DVD_W-1:0]       quotient,
    output logic      [DVS_W-1:0]       remainder
);

    import cv3_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             qbit;
    logic [DVS_W-1:0] rem_next;
    logic [DVD_W-1:0] quo_next;

    // One trial subtraction
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        qbit     = trial >= {1'b0, dvs_reg};
        rem_next = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], qbit};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> hdl/cv3_ofifo.sv
// Output queue of result words between the filter pipeline and the result channel.
`default_nettype none

module cv3_ofifo (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    input  wire cv3_pkg::cv3_res_t                 wr_word,
    input  wire logic                              stall,
    output logic                                   valid,
    output cv3_pkg::cv3_res_t                      rd_word,
    output logic      [cv3_pkg::OFIFO_CNT_W-1:0]   count
);

    import cv3_pkg::*;

    cv3_res_t               mem_reg [OFIFO_DEPTH];
    logic [OFIFO_PTR_W-1:0] wr_ptr_reg;
    logic [OFIFO_PTR_W-1:0] rd_ptr_reg;
    logic [OFIFO_CNT_W-1:0] count_reg;
    logic                   pop;

    assign pop = (count_reg != '0) && !stall;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_word;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign valid   = count_reg != '0;
    assign rd_word = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

endmodule

`default_nettype wire

>>> hdl/conv3x3_same_zero_pad_unit.sv
// Top level of the streaming 3x3 same-size convolution unit with zero padding.
//
// channel  direction  handshake            payload
// pixel    in         pix_valid/pix_stall  pixel, flush
// result   out        res_valid/res_stall  filtered, last
// config   in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One input word per clock while pix_stall is low; the result for frame position o
// is built from input word o+W+1 and passes the pipeline stages and output queue.
// After a frame_width or frame_height write the pixel channel stalls while the
// serial divider rebuilds the output row and column.
// Reset clears counters, window and queue; the line store has no clearing pass.
// The pipeline halts only when the eight-word output queue could overflow.
`default_nettype none

module conv3x3_same_zero_pad_unit #(
    parameter int MAX_WIDTH  = cv3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cv3_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = cv3_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // pixel channel
    input  wire logic                                 pix_valid,
    output logic                                      pix_stall,
    input  wire logic        [PIXEL_BITS-1:0]         pixel,
    input  wire logic                                 flush,
    // result channel
    output logic                                      res_valid,
    input  wire logic                                 res_stall,
    output logic signed      [cv3_pkg::OUT_BITS-1:0]  filtered,
    output logic                                      last,
    // config channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic        [cv3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [cv3_pkg::CFG_DATA_W-1:0] cfg_data
);

    import cv3_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WW     = COL_W + 1;
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int TOT_W  = WW + HW;
    localparam int PROD_W = WEIGHT_BITS + PIXEL_BITS + 1;
    localparam int ACC_W  = (PROD_W + 4 > OUT_BITS) ? PROD_W + 4 : OUT_BITS;
    localparam int OCC_W  = OFIFO_CNT_W + 1;

    // Configuration registers
    logic [DIM_REG_W-1:0]  frame_width_reg;
    logic [DIM_REG_W-1:0]  frame_height_reg;
    logic [CFG_DATA_W-1:0] weights_top_reg;
    logic [CFG_DATA_W-1:0] weights_middle_reg;
    logic [CFG_DATA_W-1:0] weights_bottom_reg;

    logic cfg_fire;
    logic dim_write;
    logic cfg_pend_reg;
    logic div_start_reg;

    // Effective frame size and pixel count
    logic [WW-1:0]    w_eff_reg;
    logic [WW-1:0]    w_eff_next;
    logic [HW-1:0]    h_eff_reg;
    logic [HW-1:0]    h_eff_next;
    logic [TOT_W-1:0] total_reg;

    // Frame position counters
    logic [ROW_W-1:0] in_row_reg;
    logic [ROW_W-1:0] in_row_next;
    logic [COL_W-1:0] in_col_reg;
    logic [COL_W-1:0] in_col_next;
    logic [TOT_W-1:0] out_count_reg;
    logic [TOT_W-1:0] out_count_next;
    logic [TOT_W-1:0] out_row_reg;
    logic [TOT_W-1:0] out_row_next;
    logic [WW-1:0]    out_col_reg;
    logic [WW-1:0]    out_col_next;

    // Item decode
    logic                  clr;
    logic [ROW_W-1:0]      irow0;
    logic [COL_W-1:0]      icol_a;
    logic [COL_W-1:0]      icol;
    logic [WW-1:0]         col_inc;
    logic [TOT_W-1:0]      oc0;
    logic [TOT_W-1:0]      orow0;
    logic [WW-1:0]         ocol0;
    logic [WW-1:0]         ocol_inc;
    logic                  emit;
    logic                  is_last;
    cv3_keep_t             keep;
    logic [PIXEL_BITS-1:0] pix_in;

    // Pipeline control
    logic             en;
    logic             accept;
    logic [OCC_W-1:0] occ;
    logic             div_hold;

    // Stage 1: line store read in flight
    logic                  s1_valid_reg;
    logic                  s1_emit_reg;
    logic                  s1_last_reg;
    cv3_keep_t             s1_keep_reg;
    logic [COL_W-1:0]      s1_col_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic                  s1_byp_reg;
    logic [PIXEL_BITS-1:0] s1_byp_mid_reg;
    logic [PIXEL_BITS-1:0] s1_byp_top_reg;
    logic [PIXEL_BITS-1:0] top_rd;
    logic [PIXEL_BITS-1:0] mid_rd;
    logic [PIXEL_BITS-1:0] top_eff;
    logic [PIXEL_BITS-1:0] mid_eff;

    // Stage 2: window updated
    logic      s2_emit_reg;
    logic      s2_last_reg;
    cv3_keep_t s2_keep_reg;

    // Stage 3: products registered in the taps
    logic s3_emit_reg;
    logic s3_last_reg;

    // Stage 4: row sums
    logic                    s4_emit_reg;
    logic                    s4_last_reg;
    logic signed [ACC_W-1:0] s4_row_reg [3];
    logic signed [ACC_W-1:0] row_next   [3];
    logic signed [ACC_W-1:0] sum_all;

    // Divider
    cv3_div_stat_t    div_stat;
    logic [TOT_W-1:0] div_quo;
    logic [WW-1:0]    div_rem;

    // Output queue
    cv3_res_t               push_word;
    cv3_res_t               head_word;
    logic [OFIFO_CNT_W-1:0] fifo_count;

    // Window taps
    cv3_tap_ctl_t            tap_ctl   [3][3];
    logic [PIXEL_BITS-1:0]   link      [3][1:3];
    logic signed [PROD_W-1:0] prod     [3][3];
    logic [CFG_DATA_W-1:0]   wrow      [3];
    logic [2:0]              rkeep;
    logic [2:0]              ckeep;

    // ---------------------------------------------------------------
    // Configuration port
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign dim_write = cfg_fire &&
                       ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= RST_FRAME_WIDTH;
            frame_height_reg   <= RST_FRAME_HEIGHT;
            weights_top_reg    <= RST_WEIGHTS_TOP;
            weights_middle_reg <= RST_WEIGHTS_MIDDLE;
            weights_bottom_reg <= RST_WEIGHTS_BOTTOM;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:    frame_width_reg    <= cfg_data[DIM_REG_W-1:0];
                REG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data[DIM_REG_W-1:0];
                REG_WEIGHTS_TOP:    weights_top_reg    <= cfg_data;
                REG_WEIGHTS_MIDDLE: weights_middle_reg <= cfg_data;
                REG_WEIGHTS_BOTTOM: weights_bottom_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Clamp sizes: zero counts as one, large values saturate to the maximum
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff_next = WW'(1);
        end
        else if (32'(frame_width_reg) > MAX_WIDTH)
        begin
            w_eff_next = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff_next = WW'(frame_width_reg);
        end

        if (frame_height_reg == '0)
        begin
            h_eff_next = HW'(1);
        end
        else if (32'(frame_height_reg) > MAX_HEIGHT)
        begin
            h_eff_next = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff_next = HW'(frame_height_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg     <= WW'(RST_FRAME_WIDTH);
            h_eff_reg     <= HW'(RST_FRAME_HEIGHT);
            total_reg     <= TOT_W'(RST_FRAME_WIDTH * RST_FRAME_HEIGHT);
            cfg_pend_reg  <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            w_eff_reg     <= w_eff_next;
            h_eff_reg     <= h_eff_next;
            total_reg     <= w_eff_reg * h_eff_reg;
            cfg_pend_reg  <= dim_write;
            div_start_reg <= cfg_pend_reg;
        end
    end

    // Rebuild output row and column after a size change
    cv3_div #(
        .DVD_W (TOT_W),
        .DVS_W (WW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (out_count_reg),
        .divisor   (w_eff_reg),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // hold input until the rebuilt row and column are loaded
    assign div_hold = cfg_fire || cfg_pend_reg || div_start_reg || div_stat.busy ||
                      div_stat.done;

    // ---------------------------------------------------------------
    // Flow control: room in the queue for everything in flight
    assign occ = OCC_W'(fifo_count)
               + OCC_W'(s1_valid_reg && s1_emit_reg)
               + OCC_W'(s2_emit_reg)
               + OCC_W'(s3_emit_reg)
               + OCC_W'(s4_emit_reg);
    assign en        = occ < OCC_W'(OFIFO_DEPTH);
    assign pix_stall = !en || div_hold;
    assign accept    = pix_valid && !pix_stall;

    // ---------------------------------------------------------------
    // Position decode for the incoming word
    always_comb
    begin
        clr    = out_count_reg >= total_reg;
        oc0    = clr ? '0 : out_count_reg;
        orow0  = clr ? '0 : out_row_reg;
        ocol0  = clr ? '0 : out_col_reg;
        irow0  = clr ? '0 : in_row_reg;
        icol_a = clr ? '0 : in_col_reg;
        icol   = ({1'b0, icol_a} >= w_eff_reg) ? '0 : icol_a;
        pix_in = flush ? '0 : pixel;

        emit = (irow0 >= ROW_W'(2)) || ((irow0 == ROW_W'(1)) && (icol != '0));

        // input position advance
        col_inc = {1'b0, icol} + 1'b1;
        if (col_inc >= w_eff_reg)
        begin
            in_col_next = '0;
            in_row_next = (irow0 != ROW_MAX) ? ROW_W'(irow0 + 1'b1) : irow0;
        end
        else
        begin
            in_col_next = col_inc[COL_W-1:0];
            in_row_next = irow0;
        end

        // border flags
        keep.top   = orow0 != '0;
        keep.bot   = ({1'b0, orow0} + 1'b1) < (TOT_W + 1)'(h_eff_reg);
        keep.left  = ocol0 != '0;
        keep.right = ({1'b0, ocol0} + 1'b1) < {1'b0, w_eff_reg};

        is_last  = emit && (oc0 == TOT_W'(total_reg - 1'b1));
        ocol_inc = WW'(ocol0 + 1'b1);

        // output position advance
        out_count_next = oc0;
        out_row_next   = orow0;
        out_col_next   = ocol0;
        if (emit)
        begin
            out_count_next = TOT_W'(oc0 + 1'b1);
            if (ocol_inc >= w_eff_reg)
            begin
                out_col_next = '0;
                out_row_next = TOT_W'(orow0 + 1'b1);
            end
            else
            begin
                out_col_next = ocol_inc;
            end
        end

        // end of frame
        if (is_last)
        begin
            out_count_next = '0;
            out_row_next   = '0;
            out_col_next   = '0;
            in_row_next    = '0;
            in_col_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_count_reg <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
        end
        else if (accept)
        begin
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            out_count_reg <= out_count_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
        end
        else if (div_stat.done)
        begin
            out_row_reg <= div_quo;
            out_col_reg <= div_rem;
        end
    end

    // ---------------------------------------------------------------
    // Line store: two rows, read at the column, older row shifted up on write
    assign top_eff = s1_byp_reg ? s1_byp_top_reg : top_rd;
    assign mid_eff = s1_byp_reg ? s1_byp_mid_reg : mid_rd;

    cv3_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_top_ram (
        .clk   (clk),
        .we    (en && s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (mid_eff),
        .re    (en),
        .raddr (icol),
        .rdata (top_rd)
    );

    cv3_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_mid_ram (
        .clk   (clk),
        .we    (en && s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (en),
        .raddr (icol),
        .rdata (mid_rd)
    );

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_byp_reg   <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
            s1_emit_reg  <= accept && emit;
            // same column written this edge: forward instead of the stale read
            s1_byp_reg   <= s1_valid_reg && (s1_col_reg == icol);
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_last_reg    <= is_last;
            s1_keep_reg    <= keep;
            s1_col_reg     <= icol;
            s1_pix_reg     <= pix_in;
            s1_byp_mid_reg <= s1_pix_reg;
            s1_byp_top_reg <= mid_eff;
        end
    end

    // Stages 2 to 4 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_emit_reg <= 1'b0;
            s3_emit_reg <= 1'b0;
            s4_emit_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_emit_reg <= s1_valid_reg && s1_emit_reg;
            s3_emit_reg <= s2_emit_reg;
            s4_emit_reg <= s3_emit_reg;
        end
    end

    // Stages 2 to 4 payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_last_reg <= s1_last_reg;
            s2_keep_reg <= s1_keep_reg;
            s3_last_reg <= s2_last_reg;
            s4_last_reg <= s3_last_reg;
            for (int r = 0; r < 3; r++)
            begin
                s4_row_reg[r] <= row_next[r];
            end
        end
    end

    // ---------------------------------------------------------------
    // Window: three rows of three tap cells, new pixels enter on the right
    assign wrow[0] = weights_top_reg;
    assign wrow[1] = weights_middle_reg;
    assign wrow[2] = weights_bottom_reg;

    assign link[0][3] = top_eff;
    assign link[1][3] = mid_eff;
    assign link[2][3] = s1_pix_reg;

    assign rkeep = {s2_keep_reg.bot, 1'b1, s2_keep_reg.top};
    assign ckeep = {s2_keep_reg.right, 1'b1, s2_keep_reg.left};

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                tap_ctl[r][k].en    = en;
                tap_ctl[r][k].shift = s1_valid_reg;
                tap_ctl[r][k].keep  = rkeep[r] && ckeep[k];
            end
        end
    end

    for (genvar gr = 0; gr < 3; gr++)
    begin : g_row
        for (genvar gk = 0; gk < 3; gk++)
        begin : g_tap
            if (gk == 0)
            begin : g_left
                cv3_tap #(
                    .PIXEL_BITS (PIXEL_BITS)
                ) u_tap (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .ctl     (tap_ctl[gr][gk]),
                    .pix_in  (link[gr][gk+1]),
                    .weight  ($signed(wrow[gr][WEIGHT_BITS*gk +: WEIGHT_BITS])),
                    .pix_out (),
                    .prod    (prod[gr][gk])
                );
            end
            else
            begin : g_inner
                cv3_tap #(
                    .PIXEL_BITS (PIXEL_BITS)
                ) u_tap (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .ctl     (tap_ctl[gr][gk]),
                    .pix_in  (link[gr][gk+1]),
                    .weight  ($signed(wrow[gr][WEIGHT_BITS*gk +: WEIGHT_BITS])),
                    .pix_out (link[gr][gk]),
                    .prod    (prod[gr][gk])
                );
            end
        end
    end

    // Row sums, then the full sum into the queue
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_next[r] = ACC_W'(prod[r][0]) + ACC_W'(prod[r][1]) + ACC_W'(prod[r][2]);
        end
        sum_all = s4_row_reg[0] + s4_row_reg[1] + s4_row_reg[2];
    end

    assign push_word.filtered = sum_all[OUT_BITS-1:0];
    assign push_word.last     = s4_last_reg;

    cv3_ofifo u_ofifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (en && s4_emit_reg),
        .wr_word (push_word),
        .stall   (res_stall),
        .valid   (res_valid),
        .rd_word (head_word),
        .count   (fifo_count)
    );

    assign filtered = head_word.filtered;
    assign last     = head_word.last;

endmodule

`default_nettype wire

>>> tb/conv3x3_same_zero_pad_checker.sv
// Checker for the 3x3 convolution unit: watches all channels, predicts and compares results.

module conv3x3_same_zero_pad_checker #(
    parameter int MAX_WIDTH  = cv3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cv3_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = cv3_pkg::DEF_PIXEL_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pix_valid,
    input  logic                               pix_stall,
    input  logic        [PIXEL_BITS-1:0]       pixel,
    input  logic                               flush,
    input  logic                               res_valid,
    input  logic                               res_stall,
    input  logic signed [cv3_pkg::OUT_BITS-1:0] filtered,
    input  logic                               last,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic        [cv3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [cv3_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                 fail_count,
    output int                                 pending
);
    import cv3_pkg::*;

    // Shadow copy of the registers
    logic [DIM_REG_W-1:0]  width_reg;
    logic [DIM_REG_W-1:0]  height_reg;
    logic [CFG_DATA_W-1:0] kernel_rows [3];

    // Shadow copy of the datapath state
    logic [PIXEL_BITS-1:0] line_mem [2*MAX_WIDTH];
    logic [PIXEL_BITS-1:0] win [3][3];
    logic [ROW_W-1:0]      row_pos;
    logic [DIM_REG_W-1:0]  col_pos;
    logic [20:0]           out_cnt;

    cv3_res_t expected_pixels[$];

    // Zero counts as one, oversize saturates
    function automatic int unsigned clamp_dim(logic [DIM_REG_W-1:0] r, int unsigned lim);
        if (r == 0)
            return 1;
        if (r > lim)
            return lim;
        return r;
    endfunction

    // Advance the shadow datapath by one pixel word; queue the result it produces
    task automatic conv_window_step(input logic [PIXEL_BITS-1:0] px, input logic fl);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned orow;
        int unsigned ocol;
        int r;
        int k;
        logic [PIXEL_BITS-1:0] p;
        logic [PIXEL_BITS-1:0] up;
        logic [PIXEL_BITS-1:0] mid;
        logic emit;
        logic keep_row;
        logic keep_col;
        longint acc;
        cv3_res_t res;

        w     = clamp_dim(width_reg, MAX_WIDTH);
        h     = clamp_dim(height_reg, MAX_HEIGHT);
        total = w * h;
        p     = fl ? '0 : px;

        // size shrank below what was already produced: start over
        if (out_cnt >= total)
        begin
            row_pos = '0;
            col_pos = '0;
            out_cnt = '0;
        end
        if (col_pos >= w)
            col_pos = '0;

        // line store: older row moves up, new pixel goes in
        up  = line_mem[MAX_WIDTH + col_pos];
        mid = line_mem[col_pos];
        line_mem[MAX_WIDTH + col_pos] = mid;
        line_mem[col_pos] = p;

        for (r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = p;

        emit = (row_pos >= 2) || (row_pos == 1 && col_pos >= 1);

        col_pos = col_pos + 1'b1;
        if (col_pos >= w)
        begin
            col_pos = '0;
            if (row_pos != ROW_MAX)
                row_pos = row_pos + 1'b1;
        end

        if (emit)
        begin
            orow = out_cnt / w;
            ocol = out_cnt % w;
            acc  = 0;
            for (r = 0; r < 3; r++)
            begin
                keep_row = !((r == 0 && orow == 0) || (r == 2 && orow + 1 >= h));
                for (k = 0; k < 3; k++)
                begin
                    keep_col = !((k == 0 && ocol == 0) || (k == 2 && ocol + 1 >= w));
                    if (keep_row && keep_col)
                        acc += longint'($signed(kernel_rows[r][16*k +: 16]))
                               * longint'(win[r][k]);
                end
            end
            res.filtered = acc[OUT_BITS-1:0];
            res.last     = (out_cnt == total - 1);
            expected_pixels.push_back(res);
            out_cnt = out_cnt + 1'b1;
            if (res.last)
            begin
                row_pos = '0;
                col_pos = '0;
                out_cnt = '0;
            end
        end
    endtask

    // Sample every channel at the rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        cv3_res_t exp_word;
        int i;
        if (!rst_n)
        begin
            width_reg      = RST_FRAME_WIDTH;
            height_reg     = RST_FRAME_HEIGHT;
            kernel_rows[0] = RST_WEIGHTS_TOP;
            kernel_rows[1] = RST_WEIGHTS_MIDDLE;
            kernel_rows[2] = RST_WEIGHTS_BOTTOM;
            for (i = 0; i < 2*MAX_WIDTH; i++)
                line_mem[i] = '0;
            for (i = 0; i < 9; i++)
                win[i/3][i%3] = '0;
            row_pos    = '0;
            col_pos    = '0;
            out_cnt    = '0;
            expected_pixels.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:    width_reg = cfg_data[DIM_REG_W-1:0];
                    REG_FRAME_HEIGHT:   height_reg = cfg_data[DIM_REG_W-1:0];
                    REG_WEIGHTS_TOP:    kernel_rows[0] = cfg_data;
                    REG_WEIGHTS_MIDDLE: kernel_rows[1] = cfg_data;
                    REG_WEIGHTS_BOTTOM: kernel_rows[2] = cfg_data;
                    default: ;
                endcase
            end

            // result words against the oldest expectation
            if (res_valid && !res_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: unexpected result word filtered=%0d last=%0b",
                                 filtered, last);
                end
                else
                begin
                    exp_word = expected_pixels.pop_front();
                    if (filtered !== exp_word.filtered || last !== exp_word.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: filtered exp %0d got %0d, last exp %0b got %0b",
                                     exp_word.filtered, filtered, exp_word.last, last);
                    end
                end
            end

            // input words feed the shadow datapath
            if (pix_valid && !pix_stall)
                conv_window_step(pixel, flush);

            pending = expected_pixels.size();
        end
    end

endmodule

>>> tb/conv3x3_same_zero_pad_unit_tb.sv
// Testbench top for the 3x3 convolution unit: clock, reset, stimulus and verdict.

module conv3x3_same_zero_pad_unit_tb;
    import cv3_pkg::*;

    localparam int PIX_BITS     = DEF_PIXEL_BITS;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_CYCLES  = 300;
    localparam int PAUSE_CYCLES = 12;
    localparam int DRAIN_CYCLES = 40;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         pix_valid = 1'b0;
    logic        [PIX_BITS-1:0]   pixel     = '0;
    logic                         flush     = 1'b0;
    logic                         res_stall = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic        [CFG_IDX_W-1:0]  cfg_index = '0;
    logic        [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                         pix_stall;
    logic                         res_valid;
    logic signed [OUT_BITS-1:0]   filtered;
    logic                         last;
    logic                         cfg_ready;

    int fail_count;
    int pending;
    int cycles = 0;

    // stimulus shaping
    bit quiet          = 1'b0;
    bit pressure_armed = 1'b0;
    bit pressure_done  = 1'b0;
    int hold_cnt       = 0;
    logic [DIM_REG_W-1:0] width_now  = RST_FRAME_WIDTH;
    logic [DIM_REG_W-1:0] height_now = RST_FRAME_HEIGHT;

    conv3x3_same_zero_pad_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pixel     (pixel),
        .flush     (flush),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .filtered  (filtered),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    conv3x3_same_zero_pad_checker u_conv_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pixel      (pixel),
        .flush      (flush),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .filtered   (filtered),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 12-unit clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side back-pressure: random stalls plus one long hold-off
    always @(negedge clk)
    begin : stall_drive
        logic s;
        if (!rst_n)
            s = 1'b0;
        else if (pressure_armed && !pressure_done)
        begin
            pressure_done = 1'b1;
            hold_cnt      = HOLD_CYCLES;
            s             = 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt--;
            s = 1'b1;
        end
        else
            s = quiet ? 1'b0 : ($urandom_range(99) < 12);
        res_stall <= s;
    end

    // items in a complete frame: W*H pixels then W+1 flush words
    function automatic int frame_len();
        int w;
        int h;
        w = (width_now == 0) ? 1 : (width_now > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_now;
        h = (height_now == 0) ? 1 : (height_now > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height_now;
        return w * h + w + 1;
    endfunction

    // three Q8.8 lanes, biased toward the extremes
    function automatic logic [CFG_DATA_W-1:0] pick_weights();
        logic [CFG_DATA_W-1:0] v;
        int k;
        for (k = 0; k < 3; k++)
        begin
            case ($urandom_range(5))
                0:       v[16*k +: 16] = 16'h8000;
                1:       v[16*k +: 16] = 16'h7FFF;
                2:       v[16*k +: 16] = 16'h0000;
                3:       v[16*k +: 16] = 16'h0100;
                default: v[16*k +: 16] = $urandom;
            endcase
        end
        return v;
    endfunction

    // stop offering pixels, wait for every result, then let the pipe settle
    task automatic wait_idle();
        @(negedge clk);
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (PAUSE_CYCLES) @(posedge clk);
    endtask

    // register write, only ever issued with the block drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_FRAME_WIDTH)
            width_now = data[DIM_REG_W-1:0];
        if (idx == REG_FRAME_HEIGHT)
            height_now = data[DIM_REG_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one pixel-channel word, with an optional idle gap in front
    task automatic send_word(input logic [PIX_BITS-1:0] p, input logic f);
        int gap;
        gap = (!quiet && $urandom_range(99) < 12) ? $urandom_range(1, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_valid <= 1'b1;
        pixel     <= p;
        flush     <= f;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
    endtask

    // n words of a frame; noisy flips the flush mark now and then
    task automatic run_frame(input int n_items, input bit noisy, input bit all_max);
        int n_px;
        int k;
        logic [PIX_BITS-1:0] p;
        logic f;
        n_px = frame_len() - 1;
        n_px = n_px - (n_px / (1 + (height_now == 0 ? 1 :
               (height_now > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : height_now))));
        for (k = 0; k < n_items; k++)
        begin
            case ($urandom_range(7))
                0:       p = '0;
                1:       p = '1;
                default: p = $urandom;
            endcase
            if (all_max)
                p = '1;
            f = (k >= n_px);
            if (noisy && $urandom_range(3) == 0)
                f = !f;
            send_word(p, f);
        end
    endtask

    initial
    begin : stimulus
        int random_items;
        int frame_no;
        int n;
        logic [DIM_REG_W-1:0] wsel;
        logic [DIM_REG_W-1:0] hsel;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // reset configuration: 3x3, identity kernel
        run_frame(frame_len(), 1'b0, 1'b1);

        // most negative and most positive weights on a saturated frame
        write_reg(REG_WEIGHTS_TOP, {3{16'h8000}});
        write_reg(REG_WEIGHTS_MIDDLE, {3{16'h8000}});
        write_reg(REG_WEIGHTS_BOTTOM, {3{16'h8000}});
        run_frame(frame_len(), 1'b0, 1'b1);
        write_reg(REG_WEIGHTS_TOP, {3{16'h7FFF}});
        write_reg(REG_WEIGHTS_MIDDLE, {3{16'h7FFF}});
        write_reg(REG_WEIGHTS_BOTTOM, {3{16'h7FFF}});
        run_frame(frame_len(), 1'b0, 1'b1);

        // single-pixel frames, zero sizes count as one
        write_reg(REG_WEIGHTS_MIDDLE, pick_weights());
        write_reg(REG_FRAME_WIDTH, 11'd1);
        write_reg(REG_FRAME_HEIGHT, 11'd1);
        run_frame(frame_len(), 1'b0, 1'b0);
        write_reg(REG_FRAME_WIDTH, 11'd0);
        write_reg(REG_FRAME_HEIGHT, 11'd0);
        run_frame(frame_len(), 1'b0, 1'b0);

        // early flush and late pixels
        write_reg(REG_WEIGHTS_TOP, pick_weights());
        write_reg(REG_WEIGHTS_BOTTOM, pick_weights());
        write_reg(REG_FRAME_WIDTH, 11'd3);
        write_reg(REG_FRAME_HEIGHT, 11'd2);
        run_frame(frame_len(), 1'b1, 1'b0);

        // partial frame, then a size smaller than what was produced: counters restart
        write_reg(REG_FRAME_WIDTH, 11'd4);
        write_reg(REG_FRAME_HEIGHT, 11'd4);
        run_frame(12, 1'b0, 1'b0);
        write_reg(REG_FRAME_WIDTH, 11'd2);
        write_reg(REG_FRAME_HEIGHT, 11'd3);
        run_frame(frame_len(), 1'b0, 1'b0);

        // oversize registers saturate to the maximum frame size
        write_reg(REG_FRAME_WIDTH, 11'h7FF);
        write_reg(REG_FRAME_HEIGHT, 11'd1);
        run_frame(frame_len(), 1'b0, 1'b0);
        write_reg(REG_FRAME_WIDTH, 11'd1);
        write_reg(REG_FRAME_HEIGHT, 11'h7FF);
        run_frame(frame_len(), 1'b0, 1'b0);

        // long result hold-off while pixels keep coming
        write_reg(REG_FRAME_WIDTH, 11'd16);
        write_reg(REG_FRAME_HEIGHT, 11'd8);
        pressure_armed = 1'b1;
        run_frame(frame_len(), 1'b0, 1'b0);

        // random frames, mostly small, some back to back
        random_items = 0;
        frame_no     = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            quiet = (frame_no >= 6 && frame_no < 12);
            if ($urandom_range(9) < 7)
            begin
                case ($urandom_range(19))
                    0:       wsel = 11'd0;
                    1:       wsel = $urandom_range(13, 40);
                    default: wsel = $urandom_range(1, 12);
                endcase
                case ($urandom_range(19))
                    0:       hsel = 11'd0;
                    default: hsel = $urandom_range(1, 8);
                endcase
                // upper data bits are junk for the size registers
                write_reg(REG_FRAME_WIDTH, {CFG_DATA_W'({$urandom, $urandom})} & ~48'h7FF | wsel);
                write_reg(REG_FRAME_HEIGHT, {CFG_DATA_W'({$urandom, $urandom})} & ~48'h7FF | hsel);
            end
            if ($urandom_range(1))
                write_reg(REG_WEIGHTS_TOP, pick_weights());
            if ($urandom_range(1))
                write_reg(REG_WEIGHTS_MIDDLE, pick_weights());
            if ($urandom_range(1))
                write_reg(REG_WEIGHTS_BOTTOM, pick_weights());
            n = frame_len();
            run_frame(n, ($urandom_range(4) == 0), 1'b0);
            random_items += n;
            frame_no++;
        end
        quiet = 1'b0;

        // drain and verdict
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
